/* rtl/core/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-free block allocator
// Field widths, status codes, the link word that runs along the cell chain
// and the reset maps of the block-usage bits.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int NUM_BLOCKS_DEF      = 567;
	localparam int WORDS_PER_BLOCK_DEF = 128;

	localparam int WORD_W    = 36;
	localparam int ADDR_W    = 17;
	localparam int FILE_W    = 5;
	localparam int STATUS_W  = 2;
	localparam int FREE_W    = 10;
	localparam int BLK_IDX_W = 10;

	localparam int CELL_BLOCKS = 32;
	localparam int POS_W       = $clog2(CELL_BLOCKS);

	localparam int RESERVED_COUNT = 7;
	localparam int DIR_INDEX      = 63;

	localparam logic [STATUS_W-1:0] ST_STORED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;

	typedef struct packed {
		logic                 srch;
		logic                 found;
		logic [BLK_IDX_W-1:0] idx;
	} link_t;

	function automatic logic blk_used_at_reset(input int idx, input int num_blocks);
		blk_used_at_reset = (idx >= num_blocks) || (idx < RESERVED_COUNT) ||
			(idx == DIR_INDEX);
	endfunction

	function automatic logic [CELL_BLOCKS-1:0] cell_reset_map(input int cell_idx,
		input int num_blocks);
		logic [CELL_BLOCKS-1:0] map;
		map = '0;
		for (int j = 0; j < CELL_BLOCKS; j++) begin
			map[j] = blk_used_at_reset(cell_idx * CELL_BLOCKS + j, num_blocks);
		end
		return map;
	endfunction

	function automatic int free_reset(input int num_blocks);
		int cnt;
		cnt = 0;
		for (int k = 0; k < num_blocks; k++) begin
			if (!blk_used_at_reset(k, num_blocks)) begin
				cnt++;
			end
		end
		return cnt;
	endfunction

endpackage

/* rtl/core/ffba_cell.sv */
// ----------------------------------------------------------------------------
// ffba_cell: one cell of the block-usage chain
// Holds the usage bits of a group of blocks. A search token that reaches a
// cell with a free block claims the lowest one and is replaced by its index.
// ----------------------------------------------------------------------------
module ffba_cell
	import ffba_pkg::*;
#(
	parameter int CELL_IDX   = 0,
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  link_t link_in,
	output link_t link_out
);

	localparam logic [CELL_BLOCKS-1:0] USED_RST = cell_reset_map(CELL_IDX, NUM_BLOCKS);
	localparam logic [BLK_IDX_W-1:0]   BASE_IDX = BLK_IDX_W'(CELL_IDX * CELL_BLOCKS);

	logic [CELL_BLOCKS-1:0] used_q;
	link_t                  link_q;
	logic                   any_free;
	logic [POS_W-1:0]       pos;

	assign any_free = ~&used_q;

	always_comb begin
		pos = '0;
		for (int j = CELL_BLOCKS - 1; j >= 0; j--) begin
			if (!used_q[j]) begin
				pos = POS_W'(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= USED_RST;
			link_q <= '0;
		end else begin
			if (link_in.srch && any_free) begin
				used_q[pos]  <= 1'b1;
				link_q.srch  <= 1'b0;
				link_q.found <= 1'b1;
				link_q.idx   <= BASE_IDX + BLK_IDX_W'(pos);
			end else begin
				link_q <= link_in;
			end
		end
	end

	assign link_out = link_q;

endmodule

/* rtl/core/ffba_ctrl.sv */
// ----------------------------------------------------------------------------
// ffba_ctrl: word placement control of the block allocator
// Tracks the open block, its fill level and the space failure, launches a
// first-free search along the cell chain and forms the result word.
// ----------------------------------------------------------------------------
module ffba_ctrl
	import ffba_pkg::*;
#(
	parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
	parameter int WORDS_PER_BLOCK = WORDS_PER_BLOCK_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [FILE_W-1:0]   cfg_wr_data,
	input  logic                start,
	output logic                busy,
	input  logic [WORD_W-1:0]   data_word,
	input  logic                start_of_file,
	output logic                launch,
	input  link_t               link_end,
	output logic                done,
	output logic [ADDR_W-1:0]   tape_address,
	output logic [WORD_W-1:0]   data_out,
	output logic [STATUS_W-1:0] status,
	output logic [FREE_W-1:0]   free_blocks
);

	localparam int                FILL_W   = $clog2(WORDS_PER_BLOCK + 1);
	localparam int                PROD_W   = BLK_IDX_W + 10;
	localparam logic [FREE_W-1:0] FREE_RST = FREE_W'(free_reset(NUM_BLOCKS));

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_SEARCH = 1'b1;

	logic                state_q;
	logic [FILE_W-1:0]   file_q;
	logic                open_q;
	logic                fail_q;
	logic [FILL_W-1:0]   fill_q;
	logic [ADDR_W-1:0]   base_q;
	logic [FREE_W-1:0]   free_q;
	logic [WORD_W-1:0]   word_q;
	logic                launch_q;
	logic                done_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [WORD_W-1:0]   data_q;
	logic [STATUS_W-1:0] status_q;

	logic                eff_open;
	logic                eff_fail;
	logic [FILL_W-1:0]   eff_fill;
	logic                need_search;
	logic [BLK_IDX_W:0]  idx_p1;
	logic [PROD_W-1:0]   prod;
	logic [ADDR_W-1:0]   base_new;

	assign eff_open    = open_q & ~start_of_file;
	assign eff_fail    = fail_q & ~start_of_file;
	assign eff_fill    = start_of_file ? '0 : fill_q;
	assign need_search = !eff_open || (eff_fill >= FILL_W'(WORDS_PER_BLOCK));

	assign idx_p1   = {1'b0, link_end.idx} + (BLK_IDX_W + 1)'(1);
	assign prod     = PROD_W'(idx_p1) * PROD_W'(WORDS_PER_BLOCK);
	assign base_new = prod[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			file_q   <= '0;
			open_q   <= 1'b0;
			fail_q   <= 1'b0;
			fill_q   <= '0;
			base_q   <= '0;
			free_q   <= FREE_RST;
			word_q   <= '0;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
			addr_q   <= '0;
			data_q   <= '0;
			status_q <= ST_STORED;
		end else begin
			done_q   <= 1'b0;
			launch_q <= 1'b0;
			if (cfg_wr_en) begin
				file_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						word_q <= data_word;
						open_q <= eff_open;
						fill_q <= eff_fill;
						fail_q <= eff_fail;
						if (file_q == '0) begin
							done_q   <= 1'b1;
							addr_q   <= '0;
							data_q   <= '0;
							status_q <= ST_DROPPED;
						end else if (eff_fail) begin
							done_q   <= 1'b1;
							addr_q   <= '0;
							data_q   <= '0;
							status_q <= ST_NO_SPACE;
						end else if (need_search) begin
							open_q   <= 1'b0;
							launch_q <= 1'b1;
							state_q  <= ST_SEARCH;
						end else begin
							done_q   <= 1'b1;
							addr_q   <= base_q + ADDR_W'(eff_fill);
							data_q   <= data_word;
							status_q <= ST_STORED;
							fill_q   <= eff_fill + FILL_W'(1);
						end
					end
				end
				ST_SEARCH: begin
					if (link_end.found) begin
						open_q   <= 1'b1;
						base_q   <= base_new;
						fill_q   <= FILL_W'(1);
						free_q   <= free_q - FREE_W'(1);
						done_q   <= 1'b1;
						addr_q   <= base_new;
						data_q   <= word_q;
						status_q <= ST_STORED;
						state_q  <= ST_IDLE;
					end else if (link_end.srch) begin
						fail_q   <= 1'b1;
						done_q   <= 1'b1;
						addr_q   <= '0;
						data_q   <= '0;
						status_q <= ST_NO_SPACE;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign launch       = launch_q;
	assign done         = done_q;
	assign tape_address = addr_q;
	assign data_out     = data_q;
	assign status       = status_q;
	assign free_blocks  = free_q;

`ifndef SYNTHESIS
	a_link_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(link_end.srch && link_end.found))
		else $error("search token and claimed index arrive together");

	a_link_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(link_end.srch || link_end.found) |-> (state_q == ST_SEARCH))
		else $error("chain answer outside of a search");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= FREE_RST)
		else $error("free block count above its reset value");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WORDS_PER_BLOCK))
		else $error("fill level beyond the block size");
`endif

endmodule

/* rtl/core/first_free_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_free_block_allocator: places the words of a file onto tape blocks
// A word into the open block gives its result in the cycle after acceptance and
// the next word is taken in the following cycle.
// A word that needs a new block waits for the search token to pass the whole
// cell chain, through the launch register, each cell register and the result
// register, with busy held high meanwhile; this happens once per block.
// The asynchronous reset restores the reserved blocks at once; no clear pass.
// ----------------------------------------------------------------------------
module first_free_block_allocator
	import ffba_pkg::*;
#(
	parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
	parameter int WORDS_PER_BLOCK = WORDS_PER_BLOCK_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [FILE_W-1:0]   cfg_wr_data,
	input  logic                start,
	output logic                busy,
	input  logic [WORD_W-1:0]   data_word,
	input  logic                start_of_file,
	output logic                done,
	output logic [ADDR_W-1:0]   tape_address,
	output logic [WORD_W-1:0]   data_out,
	output logic [STATUS_W-1:0] status,
	output logic [FREE_W-1:0]   free_blocks
);

	localparam int NUM_CELLS = (NUM_BLOCKS + CELL_BLOCKS - 1) / CELL_BLOCKS;

	logic  launch;
	link_t links [NUM_CELLS+1];

	assign links[0] = '{srch: launch, found: 1'b0, idx: '0};

	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		ffba_cell #(
			.CELL_IDX   (c),
			.NUM_BLOCKS (NUM_BLOCKS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.link_in  (links[c]),
			.link_out (links[c+1])
		);
	end

	ffba_ctrl #(
		.NUM_BLOCKS      (NUM_BLOCKS),
		.WORDS_PER_BLOCK (WORDS_PER_BLOCK)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.start         (start),
		.busy          (busy),
		.data_word     (data_word),
		.start_of_file (start_of_file),
		.launch        (launch),
		.link_end      (links[NUM_CELLS]),
		.done          (done),
		.tape_address  (tape_address),
		.data_out      (data_out),
		.status        (status),
		.free_blocks   (free_blocks)
	);

endmodule

/* dv/first_free_block_allocator_test.sv */
// ----------------------------------------------------------------------------
// first_free_block_allocator_test: self-checking bench for the block allocator
// Words go in on the start/busy handshake and results come back on the done
// strobe. An owner table kept in the bench predicts each result, and every
// result is checked field by field against the oldest prediction. The run
// covers directed cases, random files under three sender idling rates and a
// final pass that uses up every free block.
// ----------------------------------------------------------------------------
module first_free_block_allocator_test;
	import ffba_pkg::*;

	localparam int                WATCHDOG_LIMIT = 2000;
	localparam int                TAIL_CYCLES    = 25;
	localparam logic [FILE_W-1:0] RESERVED_MARK  = 5'o36;
	localparam logic [FILE_W-1:0] DIR_MARK       = 5'o33;
	localparam logic [WORD_W-1:0] WORD_ONES      = '1;

	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic              sof;
	} file_word_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   addr;
		logic [WORD_W-1:0]   data;
		logic [STATUS_W-1:0] st;
		logic [FREE_W-1:0]   free;
	} placement_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [FILE_W-1:0]   cfg_wr_data = '0;
	logic                start = 1'b0;
	logic                busy;
	logic [WORD_W-1:0]   data_word = '0;
	logic                start_of_file = 1'b0;
	logic                done;
	logic [ADDR_W-1:0]   tape_address;
	logic [WORD_W-1:0]   data_out;
	logic [STATUS_W-1:0] status;
	logic [FREE_W-1:0]   free_blocks;

	file_word_t pending_words[$];
	placement_t awaited_placements[$];
	logic       taken = 1'b0;
	int         idle_pct = 0;
	int         stall_cycles = 0;

	logic [FILE_W-1:0]    owner_of[NUM_BLOCKS_DEF];
	logic [BLK_IDX_W-1:0] open_blk;
	logic                 blk_is_open;
	int                   fill_cnt;
	logic                 space_fail;
	int                   free_cnt;
	logic [FILE_W-1:0]    cur_file;

	int n_words = 0;
	int n_checked = 0;
	int n_stored = 0;
	int n_dropped = 0;
	int n_no_space = 0;
	int n_errors = 0;

	first_free_block_allocator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.start        (start),
		.busy         (busy),
		.data_word    (data_word),
		.start_of_file(start_of_file),
		.done         (done),
		.tape_address (tape_address),
		.data_out     (data_out),
		.status       (status),
		.free_blocks  (free_blocks)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic clear_owner_table();
		for (int k = 0; k < NUM_BLOCKS_DEF; k++) begin
			owner_of[k] = '0;
		end
		for (int k = 0; k < RESERVED_COUNT && k < NUM_BLOCKS_DEF; k++) begin
			owner_of[k] = RESERVED_MARK;
		end
		if (DIR_INDEX < NUM_BLOCKS_DEF) begin
			owner_of[DIR_INDEX] = DIR_MARK;
		end
		free_cnt = 0;
		for (int k = 0; k < NUM_BLOCKS_DEF; k++) begin
			if (owner_of[k] == '0) begin
				free_cnt++;
			end
		end
		open_blk = '0;
		blk_is_open = 1'b0;
		fill_cnt = 0;
		space_fail = 1'b0;
		cur_file = '0;
	endtask

	function automatic placement_t place_word(input file_word_t w);
		placement_t res;
		int         k;
		res = '0;
		if (w.sof) begin
			blk_is_open = 1'b0;
			fill_cnt = 0;
			space_fail = 1'b0;
		end
		if (cur_file == '0) begin
			res.st = ST_DROPPED;
		end else if (space_fail) begin
			res.st = ST_NO_SPACE;
		end else begin
			if (fill_cnt >= WORDS_PER_BLOCK_DEF) begin
				blk_is_open = 1'b0;
			end
			if (!blk_is_open) begin
				k = 0;
				while (k < NUM_BLOCKS_DEF && owner_of[k] != '0) begin
					k++;
				end
				if (k < NUM_BLOCKS_DEF) begin
					owner_of[k] = cur_file;
					open_blk = BLK_IDX_W'(k);
					blk_is_open = 1'b1;
					fill_cnt = 0;
					free_cnt--;
				end else begin
					space_fail = 1'b1;
					res.st = ST_NO_SPACE;
				end
			end
			if (res.st == ST_STORED) begin
				res.addr = ADDR_W'((int'(open_blk) + 1) * WORDS_PER_BLOCK_DEF + fill_cnt);
				res.data = w.data;
				fill_cnt++;
			end
		end
		res.free = FREE_W'(free_cnt);
		return res;
	endfunction

	task automatic report_mismatch(input string field, input longint unsigned got,
		input longint unsigned want);
		$display("Mismatch on %s of result %0d: got 0x%0h, expected 0x%0h", field,
			n_checked, got, want);
		n_errors++;
	endtask

	always @(posedge clk) begin : watch_results
		placement_t want;
		if (arst_n) begin
			if (done) begin
				if (awaited_placements.size() == 0) begin
					$display("Result with no word waiting: address 0x%0h status %0d",
						tape_address, status);
					n_errors++;
				end else begin
					want = awaited_placements.pop_front();
					if (tape_address !== want.addr) begin
						report_mismatch("tape_address", tape_address, want.addr);
					end
					if (data_out !== want.data) begin
						report_mismatch("data_out", data_out, want.data);
					end
					if (status !== want.st) begin
						report_mismatch("status", status, want.st);
					end
					if (free_blocks !== want.free) begin
						report_mismatch("free_blocks", free_blocks, want.free);
					end
					n_checked++;
				end
			end
			if (cfg_wr_en) begin
				cur_file = cfg_wr_data;
			end
			if (start && !busy) begin
				want = place_word('{data: data_word, sof: start_of_file});
				awaited_placements.push_back(want);
				n_words++;
				case (want.st)
					ST_STORED:   n_stored++;
					ST_DROPPED:  n_dropped++;
					default:     n_no_space++;
				endcase
			end
			taken <= start && !busy;
		end
	end

	always @(negedge clk) begin : drive_words
		file_word_t nxt;
		if (arst_n && (!start || taken)) begin
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				nxt = pending_words.pop_front();
				start <= 1'b1;
				data_word <= nxt.data;
				start_of_file <= nxt.sof;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || cfg_wr_en) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return WORD_ONES;
			default: return {4'($urandom_range(0, 15)), 32'($urandom())};
		endcase
	endfunction

	task automatic queue_word(input logic [WORD_W-1:0] data, input logic sof);
		pending_words.push_back('{data: data, sof: sof});
	endtask

	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_words.size() != 0 || awaited_placements.size() != 0 ||
			start || busy);
	endtask

	task automatic set_file_number(input logic [FILE_W-1:0] value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic queue_files(input int n_items);
		int   left;
		int   len;
		logic broken;
		left = n_items;
		while (left > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(129, 260)
				: $urandom_range(1, 24);
			broken = ($urandom_range(0, 5) == 0);
			for (int j = 0; j < len; j++) begin
				queue_word(random_word(), broken ? 1'($urandom_range(0, 1)) : (j == 0));
			end
			left -= len;
		end
	endtask

	initial begin
		clear_owner_table();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		queue_word('0, 1'b0);
		queue_word(WORD_ONES, 1'b1);
		set_file_number(5'd1);
		queue_word(WORD_ONES, 1'b0);
		queue_word('0, 1'b0);
		queue_word(36'h5_5555_5555, 1'b1);
		queue_word(36'hA_AAAA_AAAA, 1'b0);
		set_file_number(5'd31);
		queue_word(36'h8_0000_0001, 1'b0);
		queue_word(36'h0_FFFF_0000, 1'b1);
		set_file_number(5'd0);
		queue_word(36'h1_2345_6789, 1'b1);
		set_file_number(5'd23);
		queue_word(36'hF_EDCB_A987, 1'b0);
		queue_word(random_word(), 1'b0);

		for (int mode = 0; mode < 3; mode++) begin
			for (int sub = 0; sub < 4; sub++) begin
				set_file_number(($urandom_range(0, 7) == 0) ? 5'd0
					: 5'($urandom_range(1, 31)));
				idle_pct = (mode == 0) ? 36 : (mode == 1) ? 55 : 0;
				queue_files(45);
			end
		end

		set_file_number(5'd9);
		idle_pct = 20;
		for (int j = 0; j < 570; j++) begin
			queue_word(random_word(), 1'b1);
		end
		for (int j = 0; j < 12; j++) begin
			queue_word(random_word(), 1'($urandom_range(0, 1)));
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Checked %0d results for %0d words: %0d stored, %0d dropped, %0d refused.",
			n_checked, n_words, n_stored, n_dropped, n_no_space);
		$display("Blocks claimed: %0d, free blocks left: %0d.",
			NUM_BLOCKS_DEF - RESERVED_COUNT - 1 - free_cnt, free_cnt);
		if (n_errors == 0 && awaited_placements.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/ffba_pkg.sv
rtl/core/ffba_cell.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_free_block_allocator.sv
dv/first_free_block_allocator_test.sv
